// File: sv/spc_pkg.sv
// Shared types and constants for the sphere pair contact block.
package spc_pkg;

  localparam int unsigned SQ_STAGES  = 32;
  localparam int unsigned DIV_STAGES = 31;
  localparam logic [31:0] NORMAL_ONE = 32'h4000_0000;

  // front to back word
  typedef struct packed {
    logic              hit;
    logic [30:0]       radii;
    logic [2:0][30:0]  mag;
    logic [2:0]        neg;
    logic [63:0]       dsq;
  } mid_t;

  // square root stage
  typedef struct packed {
    logic              v;
    logic              hit;
    logic [30:0]       radii;
    logic [2:0][30:0]  mag;
    logic [2:0]        neg;
    logic [63:0]       x;
    logic [32:0]       rem;
    logic [31:0]       root;
  } sq_t;

  // divide stage, three lanes
  typedef struct packed {
    logic              v;
    logic              hit;
    logic              zero;
    logic [30:0]       depth;
    logic [30:0]       s;
    logic [2:0]        neg;
    logic [2:0][61:0]  num;
    logic [2:0][30:0]  rem;
    logic [2:0][30:0]  quo;
  } dv_t;

  // result word
  typedef struct packed {
    logic              hit;
    logic [30:0]       depth;
    logic [31:0]       nx;
    logic [31:0]       ny;
    logic [31:0]       nz;
  } res_t;

endpackage

// File: sv/spc_front.sv
// Front part: center differences, squares and the overlap compare.
module spc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic signed [30:0] first_center_x_i,
  input  logic signed [30:0] first_center_y_i,
  input  logic signed [30:0] first_center_z_i,
  input  logic [29:0]        first_radius_i,
  input  logic signed [30:0] second_center_x_i,
  input  logic signed [30:0] second_center_y_i,
  input  logic signed [30:0] second_center_z_i,
  input  logic [29:0]        second_radius_i,
  output logic               mid_push_o,
  output spc_pkg::mid_t      mid_data_o,
  input  logic               mid_full_i
);

  logic              en;
  logic              v1_q, v2_q, v3_q;
  logic [30:0]       radii1_q, radii2_q, radii3_q;
  logic [2:0][30:0]  mag1_q, mag2_q, mag3_q;
  logic [2:0]        neg1_q, neg2_q, neg3_q;
  logic [2:0][61:0]  sq2_q;
  logic [61:0]       rsq2_q;
  logic [63:0]       dsq3_q;
  logic              hit3_q;

  logic [2:0][31:0]  diff;
  logic [2:0][30:0]  mag_d;
  logic [2:0]        neg_d;
  logic [63:0]       dsq_d;

  assign en     = !v3_q || !mid_full_i;
  assign full_o = !en;

  always_comb begin
    diff[0] = {second_center_x_i[30], second_center_x_i} -
              {first_center_x_i[30], first_center_x_i};
    diff[1] = {second_center_y_i[30], second_center_y_i} -
              {first_center_y_i[30], first_center_y_i};
    diff[2] = {second_center_z_i[30], second_center_z_i} -
              {first_center_z_i[30], first_center_z_i};
    for (int k = 0; k < 3; k++) begin
      neg_d[k] = diff[k][31];
      mag_d[k] = diff[k][31] ? 31'(~diff[k] + 32'd1) : diff[k][30:0];
    end
    dsq_d = {2'b00, sq2_q[0]} + {2'b00, sq2_q[1]} + {2'b00, sq2_q[2]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= push_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      radii1_q <= {1'b0, first_radius_i} + {1'b0, second_radius_i};
      mag1_q   <= mag_d;
      neg1_q   <= neg_d;
      for (int k = 0; k < 3; k++) begin
        sq2_q[k] <= mag1_q[k] * mag1_q[k];
      end
      rsq2_q   <= radii1_q * radii1_q;
      radii2_q <= radii1_q;
      mag2_q   <= mag1_q;
      neg2_q   <= neg1_q;
      dsq3_q   <= dsq_d;
      hit3_q   <= dsq_d < {2'b00, rsq2_q};
      radii3_q <= radii2_q;
      mag3_q   <= mag2_q;
      neg3_q   <= neg2_q;
    end
  end

  assign mid_push_o       = v3_q && en;
  assign mid_data_o.hit   = hit3_q;
  assign mid_data_o.radii = radii3_q;
  assign mid_data_o.mag   = mag3_q;
  assign mid_data_o.neg   = neg3_q;
  assign mid_data_o.dsq   = dsq3_q;

endmodule

// File: sv/spc_mid_queue.sv
// Two-entry queue between the front and back parts.
module spc_mid_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  spc_pkg::mid_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output spc_pkg::mid_t data_o
);

  spc_pkg::mid_t mem_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= !wp_q;
      if (do_pop)  rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= data_i;
  end

endmodule

// File: sv/spc_back.sv
// Back part: pipelined square root, three pipelined dividers, result queue.
module spc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          mid_empty_i,
  input  spc_pkg::mid_t mid_data_i,
  output logic          mid_pop_o,
  output logic          empty_o,
  input  logic          pop_i,
  output spc_pkg::res_t res_o
);

  spc_pkg::sq_t sq_q [spc_pkg::SQ_STAGES];
  spc_pkg::sq_t sq_d [spc_pkg::SQ_STAGES];
  spc_pkg::dv_t dp_q, dp_d;
  spc_pkg::dv_t dv_q [spc_pkg::DIV_STAGES];
  spc_pkg::dv_t dv_d [spc_pkg::DIV_STAGES];
  spc_pkg::sq_t sq_init;
  spc_pkg::dv_t last;
  spc_pkg::res_t res_d;
  spc_pkg::res_t ofifo_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;
  logic         ofull, en, opush, opop;

  function automatic spc_pkg::sq_t sq_step(spc_pkg::sq_t a);
    spc_pkg::sq_t r;
    logic [34:0]  r2;
    logic [34:0]  t;
    r    = a;
    r2   = {a.rem, a.x[63:62]};
    t    = {1'b0, a.root, 2'b01};
    r.x  = {a.x[61:0], 2'b00};
    if (r2 >= t) begin
      r.rem  = 33'(r2 - t);
      r.root = {a.root[30:0], 1'b1};
    end else begin
      r.rem  = r2[32:0];
      r.root = {a.root[30:0], 1'b0};
    end
    return r;
  endfunction

  function automatic spc_pkg::dv_t dv_step(spc_pkg::dv_t a);
    spc_pkg::dv_t r;
    logic [31:0]  r2;
    r = a;
    for (int k = 0; k < 3; k++) begin
      r2       = {a.rem[k], a.num[k][30]};
      r.num[k] = {a.num[k][60:0], 1'b0};
      if (r2 >= {1'b0, a.s}) begin
        r.rem[k] = 31'(r2 - {1'b0, a.s});
        r.quo[k] = {a.quo[k][29:0], 1'b1};
      end else begin
        r.rem[k] = r2[30:0];
        r.quo[k] = {a.quo[k][29:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] signed_q(logic [30:0] q, logic neg);
    logic [31:0] e;
    e = {1'b0, q};
    return neg ? ~e + 32'd1 : e;
  endfunction

  assign ofull     = cnt_q == 2'd2;
  assign last      = dv_q[spc_pkg::DIV_STAGES-1];
  assign en        = !last.v || !ofull;
  assign mid_pop_o = en && !mid_empty_i;
  assign opush     = en && last.v;
  assign opop      = pop_i && !empty_o;
  assign empty_o   = cnt_q == 2'd0;
  assign res_o     = ofifo_q[rp_q];

  always_comb begin
    sq_init       = '0;
    sq_init.v     = !mid_empty_i;
    sq_init.hit   = mid_data_i.hit;
    sq_init.radii = mid_data_i.radii;
    sq_init.mag   = mid_data_i.mag;
    sq_init.neg   = mid_data_i.neg;
    sq_init.x     = mid_data_i.dsq;
    sq_d[0]       = sq_step(sq_init);
    for (int i = 1; i < spc_pkg::SQ_STAGES; i++) begin
      sq_d[i] = sq_step(sq_q[i-1]);
    end

    dp_d       = '0;
    dp_d.v     = sq_q[spc_pkg::SQ_STAGES-1].v;
    dp_d.hit   = sq_q[spc_pkg::SQ_STAGES-1].hit;
    dp_d.s     = sq_q[spc_pkg::SQ_STAGES-1].root[30:0];
    dp_d.zero  = dp_d.s == 31'd0;
    dp_d.depth = sq_q[spc_pkg::SQ_STAGES-1].radii - dp_d.s;
    dp_d.neg   = sq_q[spc_pkg::SQ_STAGES-1].neg;
    for (int k = 0; k < 3; k++) begin
      dp_d.num[k] = {1'b0, sq_q[spc_pkg::SQ_STAGES-1].mag[k], 30'd0} +
                    {32'd0, dp_d.s[30:1]};
      dp_d.rem[k] = dp_d.num[k][61:31];
    end

    dv_d[0] = dv_step(dp_q);
    for (int i = 1; i < spc_pkg::DIV_STAGES; i++) begin
      dv_d[i] = dv_step(dv_q[i-1]);
    end

    res_d = '0;
    if (last.hit) begin
      res_d.hit   = 1'b1;
      res_d.depth = last.depth;
      if (last.zero) begin
        res_d.nx = spc_pkg::NORMAL_ONE;
      end else begin
        res_d.nx = signed_q(last.quo[0], last.neg[0]);
        res_d.ny = signed_q(last.quo[1], last.neg[1]);
        res_d.nz = signed_q(last.quo[2], last.neg[2]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < spc_pkg::SQ_STAGES; i++) sq_q[i] <= '0;
      for (int i = 0; i < spc_pkg::DIV_STAGES; i++) dv_q[i] <= '0;
      dp_q  <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (en) begin
        for (int i = 0; i < spc_pkg::SQ_STAGES; i++) sq_q[i] <= sq_d[i];
        for (int i = 0; i < spc_pkg::DIV_STAGES; i++) dv_q[i] <= dv_d[i];
        dp_q <= dp_d;
      end
      if (opush) wp_q <= !wp_q;
      if (opop)  rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, opush} - {1'b0, opop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (opush) ofifo_q[wp_q] <= res_d;
  end

endmodule

// File: sv/sphere_pair_contact_top.sv
// Top level of the sphere pair contact block.
// Sphere-sphere overlap test with penetration depth and unit contact normal.
// Input channel: a word (two centers in Q15.16, two radii in unsigned Q14.16)
// is taken on a rising edge with push high and full low. Result channel: while
// empty is low the oldest result sits on hit_o, depth_o and normal_*_o; it is
// taken on a rising edge with pop high. Touching or separate spheres give all
// zeros; concentric spheres give the normal (1,0,0) in Q2.30.
// One word per cycle is sustained while the receiver does not stall. From
// the accepting edge to empty falling a word passes three front stages, a
// write into the middle queue, 32 square root stages (one root bit each), one
// setup stage and 31 divide stages (one quotient bit each, three lanes), then
// the write into the two-entry result queue.
// When the receiver stalls, the back pipeline keeps flowing until the result
// queue fills, then holds; the middle queue then fills and the front holds,
// raising full. Reset empties every stage and both queues.
module sphere_pair_contact_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [30:0] first_center_x_i,
  input  logic signed [30:0] first_center_y_i,
  input  logic signed [30:0] first_center_z_i,
  input  logic [29:0]        first_radius_i,
  input  logic signed [30:0] second_center_x_i,
  input  logic signed [30:0] second_center_y_i,
  input  logic signed [30:0] second_center_z_i,
  input  logic [29:0]        second_radius_i,
  output logic               empty,
  input  logic               pop,
  output logic               hit_o,
  output logic [30:0]        depth_o,
  output logic signed [31:0] normal_x_o,
  output logic signed [31:0] normal_y_o,
  output logic signed [31:0] normal_z_o
);

  spc_pkg::mid_t mid_in, mid_out;
  spc_pkg::res_t res;
  logic          mid_push, mid_full, mid_pop, mid_empty;

  spc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push),
    .full_o            (full),
    .first_center_x_i  (first_center_x_i),
    .first_center_y_i  (first_center_y_i),
    .first_center_z_i  (first_center_z_i),
    .first_radius_i    (first_radius_i),
    .second_center_x_i (second_center_x_i),
    .second_center_y_i (second_center_y_i),
    .second_center_z_i (second_center_z_i),
    .second_radius_i   (second_radius_i),
    .mid_push_o        (mid_push),
    .mid_data_o        (mid_in),
    .mid_full_i        (mid_full)
  );

  spc_mid_queue u_mid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .empty_o (mid_empty),
    .data_o  (mid_out)
  );

  spc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_data_i  (mid_out),
    .mid_pop_o   (mid_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  assign hit_o      = res.hit;
  assign depth_o    = res.depth;
  assign normal_x_o = res.nx;
  assign normal_y_o = res.ny;
  assign normal_z_o = res.nz;

endmodule

// File: sv/spc_checker.sv
// Port-level checks for the sphere pair contact block, bound to the top.
module spc_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty,
  input  logic               pop,
  input  logic               hit_o,
  input  logic [30:0]        depth_o,
  input  logic signed [31:0] normal_x_o,
  input  logic signed [31:0] normal_y_o,
  input  logic signed [31:0] normal_z_o
);

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !hit_o) |-> (depth_o == 31'd0 && normal_x_o == 32'sd0 &&
                            normal_y_o == 32'sd0 && normal_z_o == 32'sd0))
    else $error("miss word carries nonzero fields");

  a_hit_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && hit_o) |-> depth_o != 31'd0)
    else $error("hit word with zero depth");

  a_normal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && hit_o) |-> (normal_x_o <= 32'sh4000_0000 &&
                           normal_x_o >= -32'sh4000_0000))
    else $error("normal x out of unit range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(depth_o) && $stable(hit_o)))
    else $error("waiting result word changed");

endmodule

bind sphere_pair_contact_top spc_checker u_spc_checker (.*);
